/* rtl/core/irmfr_pkg.sv */
// Package for the IR Manchester frame receiver: field widths, register
// indexes, register reset values and parameter defaults.
// No dependencies.
`default_nettype none

package irmfr_pkg;

  // Parameter defaults
  localparam int unsigned MAX_BITS_DEF   = 16;
  localparam int unsigned TICK_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int unsigned MSG_W      = 16;
  localparam int unsigned BITT_W     = 16;
  localparam int unsigned TOL_W      = 15;
  localparam int unsigned TBITS_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_BIT_TICKS    = 3'd1,
    REG_TOLERANCE    = 3'd2,
    REG_TOTAL_BITS   = 3'd3,
    REG_ACTIVE_LEVEL = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [BITT_W-1:0]  BIT_TICKS_RST  = 16'd1778;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST  = 15'd200;
  localparam logic [TBITS_W-1:0] TOTAL_BITS_RST = 5'd12;

endpackage

`default_nettype wire

/* rtl/core/ir_manchester_frame_receiver.sv */
// IR Manchester frame receiver top level: start-pulse qualification, timed
// bit sampling and the output result register.
// Depends on irmfr_pkg.
//
//  channel | ports                               | direction | beat
//  --------+-------------------------------------+-----------+---------------------
//  in      | in_valid, in_stall, in_ir_level     | input     | one tick of pin level
//  out     | out_valid, out_stall, out_message   | output    | one received frame
//  cfg     | cfg_we, cfg_index, cfg_wdata        | input     | one register write
//
// One tick is taken per clock while in_stall is low; its effect on the counters
// and state machine is registered at the accepting edge, and a finished frame
// shows on out from the output register in the cycle after that tick.
// in_stall is high only while a frame waits in the output register and the
// sink stalls it. Reset (rst_n low, synchronous) clears state, counters and
// the output valid, and loads the register defaults.
`default_nettype none

module ir_manchester_frame_receiver #(
  parameter int unsigned MAX_BITS   = irmfr_pkg::MAX_BITS_DEF,
  parameter int unsigned TICK_WIDTH = irmfr_pkg::TICK_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // tick input
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_ir_level,
  // frame output
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [irmfr_pkg::MSG_W-1:0]        out_message,
  // configuration
  input  wire                                cfg_we,
  input  wire  [irmfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [irmfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned CMP_W  = ((TICK_WIDTH > irmfr_pkg::BITT_W) ?
                                    TICK_WIDTH : irmfr_pkg::BITT_W) + 1;
  localparam int unsigned BI_W   = $clog2(MAX_BITS + 1);
  localparam int unsigned LEN_W  = ((BI_W > irmfr_pkg::TBITS_W) ?
                                    BI_W : irmfr_pkg::TBITS_W) + 1;
  localparam int unsigned WIDE_W = (MAX_BITS > irmfr_pkg::MSG_W) ?
                                   MAX_BITS : irmfr_pkg::MSG_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START2,
    PH_DATA
  } phase_t;

  // configuration registers
  logic                            enable_r;
  logic [irmfr_pkg::BITT_W-1:0]    bit_ticks_r;
  logic [irmfr_pkg::TOL_W-1:0]     tolerance_r;
  logic [irmfr_pkg::TBITS_W-1:0]   total_bits_r;
  logic                            active_level_r;

  // receiver state
  phase_t                  phase_r, phase_nxt;
  logic                    last_level_r, last_level_nxt;
  logic [TICK_WIDTH-1:0]   pulse_width_r, pulse_width_nxt;
  logic [TICK_WIDTH-1:0]   countdown_r, countdown_nxt;
  logic [BI_W-1:0]         bit_index_r, bit_index_nxt;
  logic [MAX_BITS-1:0]     shift_word_r, shift_word_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [irmfr_pkg::MSG_W-1:0]   out_message_r, out_message_nxt;

  logic                    in_accept;
  logic                    out_take;
  logic                    act;
  logic                    frame_done;

  logic [CMP_W-1:0]        w_ext, tol_ext, half_ext, tmax_ext;
  logic [CMP_W-1:0]        bit_ext, qtr3_ext;
  logic [irmfr_pkg::BITT_W+1:0] three_bits;
  logic                    width_ok;
  logic [TICK_WIDTH-1:0]   bit_load, qtr3_load;
  logic [LEN_W-1:0]        frame_len, idx_ext;
  logic [WIDE_W-1:0]       shift_wide;

  // handshake
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_message = out_message_r;

  assign act = (in_ir_level == active_level_r);

  // start pulse window: half - tol < w < half + tol, done without negatives
  assign w_ext    = CMP_W'(pulse_width_r);
  assign tol_ext  = CMP_W'(tolerance_r);
  assign half_ext = CMP_W'(bit_ticks_r[irmfr_pkg::BITT_W-1:1]);
  assign width_ok = ((w_ext + tol_ext) > half_ext) && (w_ext < (half_ext + tol_ext));

  // countdown loads, clamped to the tick counter range
  assign tmax_ext   = CMP_W'({TICK_WIDTH{1'b1}});
  assign bit_ext    = CMP_W'(bit_ticks_r);
  assign three_bits = {1'b0, bit_ticks_r, 1'b0} + {2'b00, bit_ticks_r};
  assign qtr3_ext   = CMP_W'(three_bits[irmfr_pkg::BITT_W+1:2]);
  assign bit_load   = (bit_ext > tmax_ext) ? {TICK_WIDTH{1'b1}} :
                      bit_ext[TICK_WIDTH-1:0];
  assign qtr3_load  = (qtr3_ext > tmax_ext) ? {TICK_WIDTH{1'b1}} :
                      qtr3_ext[TICK_WIDTH-1:0];

  // frame length, saturated to the shift register size
  assign frame_len = (LEN_W'(total_bits_r) > LEN_W'(MAX_BITS)) ?
                     LEN_W'(MAX_BITS) : LEN_W'(total_bits_r);
  assign idx_ext   = LEN_W'(bit_index_r);

  assign shift_wide = WIDE_W'(shift_word_r);

  // receiver next state for one tick
  always_comb begin
    phase_nxt       = phase_r;
    last_level_nxt  = last_level_r;
    pulse_width_nxt = pulse_width_r;
    countdown_nxt   = countdown_r;
    bit_index_nxt   = bit_index_r;
    shift_word_nxt  = shift_word_r;
    frame_done      = 1'b0;

    if (!enable_r) begin
      phase_nxt       = PH_IDLE;
      pulse_width_nxt = '0;
      last_level_nxt  = in_ir_level;
    end else begin
      last_level_nxt = in_ir_level;
      unique case (phase_r)
        PH_START2, PH_DATA: begin
          if (countdown_r > TICK_WIDTH'(1)) begin
            countdown_nxt = countdown_r - TICK_WIDTH'(1);
          end else if (phase_r == PH_START2) begin
            // second start bit must be at the active level
            if (act) begin
              phase_nxt     = PH_DATA;
              countdown_nxt = bit_load;
            end else begin
              phase_nxt       = PH_IDLE;
              pulse_width_nxt = '0;
            end
          end else if (idx_ext >= frame_len) begin
            frame_done      = 1'b1;
            phase_nxt       = PH_IDLE;
            pulse_width_nxt = '0;
          end else begin
            // timed data sample, LSB first
            for (int i = 0; i < MAX_BITS; i++) begin
              if (act && (idx_ext == LEN_W'(i))) begin
                shift_word_nxt[i] = 1'b1;
              end
            end
            bit_index_nxt = bit_index_r + BI_W'(1);
            countdown_nxt = bit_load;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (in_ir_level != last_level_r) begin
            if (act) begin
              pulse_width_nxt = TICK_WIDTH'(1);
            end else if (width_ok) begin
              phase_nxt      = PH_START2;
              countdown_nxt  = qtr3_load;
              bit_index_nxt  = '0;
              shift_word_nxt = '0;
            end
          end else if (act && (pulse_width_r != {TICK_WIDTH{1'b1}})) begin
            pulse_width_nxt = pulse_width_r + TICK_WIDTH'(1);
          end
        end
      endcase
    end
  end

  // output register next value
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_take;
    out_message_nxt = out_message_r;
    if (in_accept && frame_done) begin
      out_valid_nxt   = 1'b1;
      out_message_nxt = shift_wide[irmfr_pkg::MSG_W-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      bit_ticks_r    <= irmfr_pkg::BIT_TICKS_RST;
      tolerance_r    <= irmfr_pkg::TOLERANCE_RST;
      total_bits_r   <= irmfr_pkg::TOTAL_BITS_RST;
      active_level_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irmfr_pkg::REG_ENABLE:       enable_r       <= cfg_wdata[0];
        irmfr_pkg::REG_BIT_TICKS:    bit_ticks_r    <= cfg_wdata[irmfr_pkg::BITT_W-1:0];
        irmfr_pkg::REG_TOLERANCE:    tolerance_r    <= cfg_wdata[irmfr_pkg::TOL_W-1:0];
        irmfr_pkg::REG_TOTAL_BITS:   total_bits_r   <= cfg_wdata[irmfr_pkg::TBITS_W-1:0];
        irmfr_pkg::REG_ACTIVE_LEVEL: active_level_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      last_level_r  <= 1'b1;
      pulse_width_r <= '0;
      countdown_r   <= '0;
      bit_index_r   <= '0;
      shift_word_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r       <= phase_nxt;
        last_level_r  <= last_level_nxt;
        pulse_width_r <= pulse_width_nxt;
        countdown_r   <= countdown_nxt;
        bit_index_r   <= bit_index_nxt;
        shift_word_r  <= shift_word_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_message_r <= out_message_nxt;
  end

  // a new frame appears only from a tick taken in the data phase
  a_frame_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept) && ($past(phase_r) == PH_DATA))
    else $error("frame emitted outside the data phase");

  // the bit counter never passes the shift register size
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(bit_index_r) <= LEN_W'(MAX_BITS))
    else $error("bit index past shift register");

  // input is held back only by a waiting, stalled frame
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a pending frame");

  // a tick that starts a frame must see an idle receiver first
  a_arm_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START2) && ($past(phase_r) != PH_START2) |->
    ($past(phase_r) == PH_IDLE) && $past(in_accept))
    else $error("start2 entered from a busy phase");

endmodule

`default_nettype wire

/* dv/ir_manchester_frame_receiver_tb.sv */
`timescale 1ns / 100ps
// Testbench for ir_manchester_frame_receiver: feeds pin-level ticks, decodes them with an
// in-bench frame decoder and checks every received frame against it.
// Depends on irmfr_pkg and the receiver RTL.

module ir_manchester_frame_receiver_tb;

  localparam int unsigned QUIET_LIMIT = 4000;  // cycles with no beat before giving up
  localparam int unsigned TICK_BUDGET = 1850;  // ticks for the whole run
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CFG_SETTLE  = 4;
  localparam logic [irmfr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED =
    irmfr_pkg::REG_ACTIVE_LEVEL + 3'd1;

  typedef enum logic [1:0] {RX_IDLE, RX_START2, RX_DATA} rx_phase_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_ir_level;
  logic                             out_valid;
  logic                             out_stall;
  logic [irmfr_pkg::MSG_W-1:0]      out_message;
  logic                             cfg_we;
  logic [irmfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [irmfr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ir_manchester_frame_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ir_level(in_ir_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_message(out_message),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Decoder copy of the registers
  logic                          m_enable;
  logic [irmfr_pkg::BITT_W-1:0]  m_bit_ticks;
  logic [irmfr_pkg::TOL_W-1:0]   m_tol;
  logic [irmfr_pkg::TBITS_W-1:0] m_total;
  logic                          m_active;

  // Decoder state
  rx_phase_t                     rx_phase;
  logic                          rx_last;
  logic [15:0]                   rx_width;
  logic [15:0]                   rx_count;
  logic [4:0]                    rx_bitno;
  logic [irmfr_pkg::MSG_W-1:0]   rx_word;

  logic [irmfr_pkg::MSG_W-1:0]   frames_due[$];
  logic [irmfr_pkg::MSG_W-1:0]   due_msg;

  int  err_cnt = 0;
  int  frames_seen = 0;
  int  ticks_sent = 0;
  int  quiet_cycles = 0;
  int  sink_hold = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_error(input string what);
    err_cnt++;
    $display("[%0t] ERROR %s", $time, what);
  endtask

  function automatic void decoder_reset();
    m_enable    = 1'b0;
    m_bit_ticks = irmfr_pkg::BIT_TICKS_RST;
    m_tol       = irmfr_pkg::TOLERANCE_RST;
    m_total     = irmfr_pkg::TOTAL_BITS_RST;
    m_active    = 1'b0;
    rx_phase    = RX_IDLE;
    rx_last     = 1'b1;
    rx_width    = '0;
    rx_count    = '0;
    rx_bitno    = '0;
    rx_word     = '0;
  endfunction

  function automatic void decoder_write(input logic [irmfr_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [irmfr_pkg::CFG_DATA_W-1:0] val);
    unique case (idx)
      irmfr_pkg::REG_ENABLE:       m_enable    = val[0];
      irmfr_pkg::REG_BIT_TICKS:    m_bit_ticks = val[irmfr_pkg::BITT_W-1:0];
      irmfr_pkg::REG_TOLERANCE:    m_tol       = val[irmfr_pkg::TOL_W-1:0];
      irmfr_pkg::REG_TOTAL_BITS:   m_total     = val[irmfr_pkg::TBITS_W-1:0];
      irmfr_pkg::REG_ACTIVE_LEVEL: m_active    = val[0];
      default: ;
    endcase
  endfunction

  // One tick through the decoder; a finished frame goes to frames_due
  function automatic void decode_tick(input logic lvl);
    logic act;
    int   half, wid, tol, flen;
    act = (lvl == m_active);
    if (!m_enable) begin
      rx_phase = RX_IDLE;
      rx_width = '0;
      rx_last  = lvl;
      return;
    end
    flen = (int'(m_total) > int'(irmfr_pkg::MAX_BITS_DEF)) ?
           int'(irmfr_pkg::MAX_BITS_DEF) : int'(m_total);
    if (rx_phase != RX_IDLE) begin
      // timed samples only; edges are ignored here
      if (rx_count > 16'd1) begin
        rx_count = rx_count - 16'd1;
      end else if (rx_phase == RX_START2) begin
        if (act) begin
          rx_phase = RX_DATA;
          rx_count = m_bit_ticks;
        end else begin
          rx_phase = RX_IDLE;
          rx_width = '0;
        end
      end else if (int'(rx_bitno) >= flen) begin
        frames_due.push_back(rx_word);
        rx_phase = RX_IDLE;
        rx_width = '0;
      end else begin
        if (act) rx_word[rx_bitno[3:0]] = 1'b1;
        rx_bitno = rx_bitno + 5'd1;
        rx_count = m_bit_ticks;
      end
    end else if (lvl != rx_last) begin
      if (act) begin
        rx_width = 16'd1;
      end else begin
        // pulse judged on its trailing edge; bounds are signed
        half = int'(m_bit_ticks >> 1);
        wid  = int'(rx_width);
        tol  = int'(m_tol);
        if (wid > half - tol && wid < half + tol) begin
          rx_phase = RX_START2;
          rx_count = 16'((int'(m_bit_ticks) * 3) / 4);
          rx_bitno = '0;
          rx_word  = '0;
        end
      end
    end else if (act && rx_width != 16'hFFFF) begin
      rx_width = rx_width + 16'd1;
    end
    rx_last = lvl;
  endfunction

  // One tick beat, with a random gap ahead of it while src_idle is set
  task automatic send_tick(input logic lvl);
    int gap;
    gap = src_idle ? int'($urandom_range(0, 9)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_ir_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_tick(lvl);
    ticks_sent++;
  endtask

  // Register write once nothing is in flight
  task automatic write_reg(input logic [irmfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [irmfr_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    decoder_write(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] en, input logic [15:0] bt, input logic [15:0] tol,
                            input logic [15:0] nbits, input logic [15:0] act);
    write_reg(irmfr_pkg::REG_ENABLE, en);
    write_reg(irmfr_pkg::REG_BIT_TICKS, bt);
    write_reg(irmfr_pkg::REG_TOLERANCE, tol);
    write_reg(irmfr_pkg::REG_TOTAL_BITS, nbits);
    write_reg(irmfr_pkg::REG_ACTIVE_LEVEL, act);
  endtask

  function automatic int frame_bits();
    return (int'(m_total) > int'(irmfr_pkg::MAX_BITS_DEF)) ?
           int'(irmfr_pkg::MAX_BITS_DEF) : int'(m_total);
  endfunction

  function automatic int pick_width(input bit in_window);
    int half, lo, hi;
    half = int'(m_bit_ticks >> 1);
    lo = half - int'(m_tol) + 1;
    hi = half + int'(m_tol) - 1;
    if (lo < 1) lo = 1;
    if (hi > half + 4) hi = half + 4;
    if (!in_window || hi < lo) return int'($urandom_range(1, half + int'(m_tol) + 3));
    return int'($urandom_range(lo, hi));
  endfunction

  // Idle lead-in, start pulse of pw ticks, second start bit, Manchester data
  // (second half carries the bit), then an idle tail past the last sample
  task automatic send_frame(input int pw, input logic [15:0] data, input int nbits,
                            input int noise_pct);
    int   bt, span, k, r;
    logic bitv;
    bt   = int'(m_bit_ticks);
    span = bt + nbits * bt + bt + 2;
    repeat ($urandom_range(2, 5)) send_tick(~m_active);
    repeat (pw) send_tick(m_active);
    for (int d = 0; d < span; d++) begin
      if (d < bt / 2) begin
        bitv = 1'b0;
      end else if (d < bt) begin
        bitv = 1'b1;
      end else if (d < bt + nbits * bt) begin
        k = (d - bt) / bt;
        r = (d - bt) % bt;
        bitv = (r < bt / 2) ? ~data[k] : data[k];
      end else begin
        bitv = 1'b0;
      end
      if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) bitv = ~bitv;
      send_tick(bitv ? m_active : ~m_active);
    end
  endtask

  // Sink: per frame a random hold while sink_idle is set, or a forced sink_hold, counted while a frame is offered
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) stall_left = sink_idle ? $urandom_range(0, 9) : 0;
      else if (out_valid === 1'b1 && stall_left > 0) stall_left--;
      if (sink_hold > 0) begin
        stall_left = sink_hold;
        sink_hold  = 0;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Frame checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (frames_due.size() == 0) begin
        report_error($sformatf("unexpected frame %h", out_message));
      end else begin
        due_msg = frames_due.pop_front();
        if (out_message !== due_msg)
          report_error($sformatf("message %h, expected %h", out_message, due_msg));
      end
      frames_seen++;
    end
  end

  // Watchdog on beats of any kind
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("ir_manchester_frame_receiver verification failed");
      $finish;
    end
  end

  // Disabled after reset: pin activity must not arm anything
  task automatic test_disabled_ticks();
    repeat (3) send_tick(1'b1);
    repeat (20) send_tick(1'b0);
    repeat (12) send_tick(1'($urandom_range(0, 1)));
  endtask

  // Reset register values: pulses well short of the default half bit do not arm
  task automatic test_reset_defaults();
    src_idle = 1'b0;
    write_reg(irmfr_pkg::REG_ENABLE, 16'd1);
    repeat (3) send_tick(~m_active);
    repeat (20) send_tick(m_active);
    repeat (10) send_tick(~m_active);
    repeat (60) send_tick(m_active);
    repeat (10) send_tick(~m_active);
    src_idle = 1'b1;
  endtask

  // Pulse widths on and around the acceptance window bounds
  task automatic test_start_window();
    set_config(16'd1, 16'd8, 16'd2, 16'd2, 16'd0);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    for (int w = 1; w <= 7; w++) send_frame(w, 16'($urandom), 2, 0);
    write_reg(irmfr_pkg::REG_TOLERANCE, 16'd0);
    send_frame(4, 16'($urandom), 2, 0);
  endtask

  // Zero, one, full and over-range frame lengths
  task automatic test_frame_lengths();
    set_config(16'd1, 16'd6, 16'd2, 16'd0, 16'd0);
    send_frame(3, 16'hFFFF, 0, 0);
    write_reg(irmfr_pkg::REG_TOTAL_BITS, 16'd1);
    send_frame(3, 16'hFFFF, 1, 0);
    write_reg(irmfr_pkg::REG_TOTAL_BITS, 16'd16);
    send_frame(3, 16'hFFFF, 16, 0);
    write_reg(irmfr_pkg::REG_TOTAL_BITS, 16'hFFFF);
    send_frame(3, 16'hA5C3, 16, 0);
  endtask

  // Active-high line, then a level swap in the middle of a pulse
  task automatic test_active_high();
    set_config(16'd1, 16'd8, 16'd2, 16'd8, 16'd1);
    send_frame(4, 16'h00B4, 8, 0);
    repeat (3) send_tick(1'b0);
    repeat (2) send_tick(1'b1);
    write_reg(irmfr_pkg::REG_ACTIVE_LEVEL, 16'd0);
    send_frame(4, 16'h005A, 8, 0);
  endtask

  // Tolerance beyond half a bit: any short pulse arms
  task automatic test_wide_tolerance();
    set_config(16'd1, 16'd10, 16'hFFFF, 16'd5, 16'd0);
    send_frame(1, 16'($urandom), 5, 0);
    send_frame(9, 16'($urandom), 5, 0);
    send_frame(12, 16'($urandom), 5, 0);
  endtask

  // Second start sample on an idle line drops back to idle
  task automatic test_abort_second_start();
    set_config(16'd1, 16'd8, 16'd3, 16'd6, 16'd0);
    repeat (3) send_tick(~m_active);
    repeat (4) send_tick(m_active);
    repeat (12) send_tick(~m_active);
    send_frame(4, 16'($urandom), 6, 0);
  endtask

  // Bit periods below the legal range
  task automatic test_short_periods();
    for (int bt = 0; bt <= 3; bt++) begin
      set_config(16'd1, 16'(bt), 16'd2, 16'd3, 16'd0);
      send_frame(1, 16'($urandom), 3, 0);
      send_frame(2, 16'($urandom), 3, 0);
    end
  endtask

  // Enable dropped in the middle of a frame, then re-armed
  task automatic test_enable_drop();
    set_config(16'd1, 16'd8, 16'd2, 16'd8, 16'd0);
    repeat (3) send_tick(~m_active);
    repeat (4) send_tick(m_active);
    repeat (20) send_tick(1'($urandom_range(0, 1)));
    write_reg(irmfr_pkg::REG_ENABLE, 16'd0);
    repeat (10) send_tick(1'($urandom_range(0, 1)));
    write_reg(irmfr_pkg::REG_ENABLE, 16'd1);
    send_frame(4, 16'($urandom), 8, 0);
  endtask

  // Largest period and tolerance: arms, then is cut short by disabling
  task automatic test_max_period();
    set_config(16'd1, 16'hFFFF, 16'h7FFF, 16'd12, 16'd0);
    repeat (3) send_tick(~m_active);
    repeat (3) send_tick(m_active);
    repeat (20) send_tick(1'($urandom_range(0, 1)));
    write_reg(irmfr_pkg::REG_ENABLE, 16'd0);
    repeat (5) send_tick(1'($urandom_range(0, 1)));
  endtask

  // Sink holds a frame for a long stretch while ticks keep coming
  task automatic test_backpressure();
    set_config(16'd1, 16'd4, 16'd1, 16'd2, 16'd0);
    sink_hold = HOLD_CYCLES;
    repeat (4) send_frame(2, 16'($urandom), 2, 0);
  endtask

  // Random settings until the tick budget is spent; mostly clean frames,
  // some bad widths, noise and garbage
  task automatic test_random();
    int bt, nb;
    while (ticks_sent < int'(TICK_BUDGET)) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      bt = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 24) : $urandom_range(4, 10);
      set_config(16'($urandom_range(0, 9) != 0), 16'(bt), 16'($urandom_range(0, bt / 2 + 1)),
                 ($urandom_range(0, 9) == 0) ? 16'($urandom_range(17, 31))
                                             : 16'($urandom_range(0, 16)),
                 16'($urandom_range(0, 1)));
      repeat ($urandom_range(2, 5)) begin
        if (ticks_sent >= int'(TICK_BUDGET)) break;
        nb = frame_bits();
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(5, 30)) send_tick(1'($urandom_range(0, 1)));
          1: send_frame(pick_width(1'b0), 16'($urandom), nb, 0);
          2: send_frame(pick_width(1'b1), 16'($urandom), nb, 10);
          default: send_frame(pick_width(1'b1), 16'($urandom), nb, 0);
        endcase
      end
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_ir_level <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= irmfr_pkg::REG_ENABLE;
    cfg_wdata   <= '0;
    decoder_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_disabled_ticks();
    test_reset_defaults();
    test_start_window();
    test_frame_lengths();
    test_active_high();
    test_wide_tolerance();
    test_abort_second_start();
    test_short_periods();
    test_enable_drop();
    test_max_period();
    test_backpressure();
    test_random();

    // drain: every frame back, then a quiet tail for strays
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0)
      $display("ir_manchester_frame_receiver verification clean");
    else
      $display("ir_manchester_frame_receiver verification failed");
    $finish;
  end

endmodule
